>>> rtl/core/tsp_pkg.sv
// tsp_pkg: shared types, phase and mode codes, register map and reset values
// for the traffic signal phase controller; no dependencies
`timescale 1ns / 1ps

package tsp_pkg;

	// timing defaults
	localparam int TICKS_PER_SECOND_DEF = 10;
	localparam logic [7:0] EMERGENCY_HOLD_SECS = 8'd10;

	// register map (index = byte address / 4)
	localparam int CFG_ADDR_W = 5;
	localparam logic [2:0] REG_LEFT_GREEN  = 3'd0;
	localparam logic [2:0] REG_BASE_GREEN  = 3'd1;
	localparam logic [2:0] REG_SECS_PER_VEH = 3'd2;
	localparam logic [2:0] REG_MIN_GREEN   = 3'd3;
	localparam logic [2:0] REG_MAX_GREEN   = 3'd4;
	localparam logic [2:0] REG_YELLOW      = 3'd5;
	localparam logic [2:0] REG_ALL_RED     = 3'd6;
	localparam logic [2:0] REG_WALK        = 3'd7;

	localparam logic [7:0] RST_LEFT_GREEN   = 8'd10;
	localparam logic [7:0] RST_BASE_GREEN   = 8'd15;
	localparam logic [3:0] RST_SECS_PER_VEH = 4'd2;
	localparam logic [7:0] RST_MIN_GREEN    = 8'd10;
	localparam logic [7:0] RST_MAX_GREEN    = 8'd60;
	localparam logic [7:0] RST_YELLOW       = 8'd3;
	localparam logic [7:0] RST_ALL_RED      = 8'd2;
	localparam logic [7:0] RST_WALK         = 8'd10;

	// light codes
	localparam logic [1:0] LIGHT_RED    = 2'd0;
	localparam logic [1:0] LIGHT_YELLOW = 2'd1;
	localparam logic [1:0] LIGHT_GREEN  = 2'd2;

	typedef enum logic [3:0] {
		PH_NS_LEFT_GREEN  = 4'd0,
		PH_NS_LEFT_YELLOW = 4'd1,
		PH_NS_LEFT_RED    = 4'd2,
		PH_NS_GREEN       = 4'd3,
		PH_NS_YELLOW      = 4'd4,
		PH_NS_RED         = 4'd5,
		PH_EW_LEFT_GREEN  = 4'd6,
		PH_EW_LEFT_YELLOW = 4'd7,
		PH_EW_LEFT_RED    = 4'd8,
		PH_EW_GREEN       = 4'd9,
		PH_EW_YELLOW      = 4'd10,
		PH_EW_RED         = 4'd11,
		PH_WALK           = 4'd12,
		PH_EMG_GREEN      = 4'd13,
		PH_EMG_YELLOW     = 4'd14,
		PH_STOPPED        = 4'd15
	} phase_t;

	typedef enum logic [1:0] {
		RM_NORMAL  = 2'd0,
		RM_TO_EMG  = 2'd1,
		RM_TO_WALK = 2'd2,
		RM_EXIT    = 2'd3
	} ret_mode_t;

	// position of a cycle phase inside its three-phase group
	typedef enum logic [1:0] {
		SLOT_GREEN,
		SLOT_YELLOW,
		SLOT_RED,
		SLOT_SPECIAL
	} slot_t;

	typedef struct packed {
		logic [7:0] left_green_secs;
		logic [7:0] base_green_secs;
		logic [3:0] secs_per_vehicle;
		logic [7:0] min_green_secs;
		logic [7:0] max_green_secs;
		logic [7:0] yellow_secs;
		logic [7:0] all_red_secs;
		logic [7:0] walk_secs;
	} cfg_t;

	typedef struct packed {
		logic       ped_request;
		logic [1:0] ped_direction;
		logic       emergency_request;
		logic [1:0] emergency_approach;
		logic [7:0] ns_vehicles;
		logic [7:0] ew_vehicles;
		logic       shutdown;
	} in_item_t;

	// controller state seen after one tick
	typedef struct packed {
		phase_t     phase;
		logic [7:0] secs_rem;
		logic [1:0] serving_dir;
		logic       ped_latched;
	} step_res_t;

	function automatic slot_t phase_slot(input phase_t p);
		slot_t s;
		case (p)
			PH_NS_LEFT_GREEN, PH_NS_GREEN, PH_EW_LEFT_GREEN, PH_EW_GREEN: s = SLOT_GREEN;
			PH_NS_LEFT_YELLOW, PH_NS_YELLOW, PH_EW_LEFT_YELLOW, PH_EW_YELLOW: s = SLOT_YELLOW;
			PH_NS_LEFT_RED, PH_NS_RED, PH_EW_LEFT_RED, PH_EW_RED: s = SLOT_RED;
			default: s = SLOT_SPECIAL;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/tsp_cfg.sv
// tsp_cfg: apb-style configuration registers of the phase controller
// depends on tsp_pkg
`timescale 1ns / 1ps

module tsp_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tsp_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output tsp_pkg::cfg_t                      cfg
);

	tsp_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx    = paddr[tsp_pkg::CFG_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_green_secs  <= tsp_pkg::RST_LEFT_GREEN;
			cfg_q.base_green_secs  <= tsp_pkg::RST_BASE_GREEN;
			cfg_q.secs_per_vehicle <= tsp_pkg::RST_SECS_PER_VEH;
			cfg_q.min_green_secs   <= tsp_pkg::RST_MIN_GREEN;
			cfg_q.max_green_secs   <= tsp_pkg::RST_MAX_GREEN;
			cfg_q.yellow_secs      <= tsp_pkg::RST_YELLOW;
			cfg_q.all_red_secs     <= tsp_pkg::RST_ALL_RED;
			cfg_q.walk_secs        <= tsp_pkg::RST_WALK;
		end else if (wr_en) begin
			case (idx)
				tsp_pkg::REG_LEFT_GREEN:   cfg_q.left_green_secs  <= pwdata[7:0];
				tsp_pkg::REG_BASE_GREEN:   cfg_q.base_green_secs  <= pwdata[7:0];
				tsp_pkg::REG_SECS_PER_VEH: cfg_q.secs_per_vehicle <= pwdata[3:0];
				tsp_pkg::REG_MIN_GREEN:    cfg_q.min_green_secs   <= pwdata[7:0];
				tsp_pkg::REG_MAX_GREEN:    cfg_q.max_green_secs   <= pwdata[7:0];
				tsp_pkg::REG_YELLOW:       cfg_q.yellow_secs      <= pwdata[7:0];
				tsp_pkg::REG_ALL_RED:      cfg_q.all_red_secs     <= pwdata[7:0];
				tsp_pkg::REG_WALK:         cfg_q.walk_secs        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tsp_pkg::REG_LEFT_GREEN:   prdata = {24'd0, cfg_q.left_green_secs};
			tsp_pkg::REG_BASE_GREEN:   prdata = {24'd0, cfg_q.base_green_secs};
			tsp_pkg::REG_SECS_PER_VEH: prdata = {28'd0, cfg_q.secs_per_vehicle};
			tsp_pkg::REG_MIN_GREEN:    prdata = {24'd0, cfg_q.min_green_secs};
			tsp_pkg::REG_MAX_GREEN:    prdata = {24'd0, cfg_q.max_green_secs};
			tsp_pkg::REG_YELLOW:       prdata = {24'd0, cfg_q.yellow_secs};
			tsp_pkg::REG_ALL_RED:      prdata = {24'd0, cfg_q.all_red_secs};
			tsp_pkg::REG_WALK:         prdata = {24'd0, cfg_q.walk_secs};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/core/tsp_ctrl.sv
// tsp_ctrl: phase state machine, latches and second counter, one tick per step
// depends on tsp_pkg
`timescale 1ns / 1ps

module tsp_ctrl #(
	parameter int TICKS_PER_SECOND = tsp_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  tsp_pkg::in_item_t   item,
	input  tsp_pkg::cfg_t       cfg,
	output tsp_pkg::step_res_t  res
);

	localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

	tsp_pkg::phase_t    phase_q, n_phase, enter_ph;
	tsp_pkg::ret_mode_t rm_q, n_rm;
	logic [TICK_W-1:0]  tick_q, n_tick;
	logic [TICK_W:0]    tick_inc;
	logic [7:0]         len_q, n_len, len_dec, enter_len;
	logic               ped_q, n_ped;
	logic [1:0]         ped_dir_q, n_ped_dir;
	logic               emg_q, n_emg;
	logic [1:0]         emg_dir_q, n_emg_dir;
	logic [1:0]         serv_q, n_serv;
	logic [7:0]         saved_q, n_saved;
	logic               enter_en, use_saved, pre;
	logic [7:0]         ns_len, ew_len;
	tsp_pkg::slot_t     slot;

	function automatic logic [7:0] straight_len(input logic [7:0] veh, input tsp_pkg::cfg_t c);
		logic [12:0] t;
		t = {5'd0, c.base_green_secs} + ({5'd0, veh} * {9'd0, c.secs_per_vehicle});
		if (t < {5'd0, c.min_green_secs}) t = {5'd0, c.min_green_secs};
		if (t > {5'd0, c.max_green_secs}) t = {5'd0, c.max_green_secs};
		return t[7:0];
	endfunction

	assign ns_len   = straight_len(item.ns_vehicles, cfg);
	assign ew_len   = straight_len(item.ew_vehicles, cfg);
	assign slot     = tsp_pkg::phase_slot(phase_q);
	assign tick_inc = {1'b0, tick_q} + {{TICK_W{1'b0}}, 1'b1};

	// next state
	always_comb begin
		n_phase   = phase_q;
		n_rm      = rm_q;
		n_tick    = tick_q;
		n_len     = len_q;
		n_ped     = ped_q;
		n_ped_dir = ped_dir_q;
		n_emg     = emg_q;
		n_emg_dir = emg_dir_q;
		n_serv    = serv_q;
		n_saved   = saved_q;
		enter_en  = 1'b0;
		enter_ph  = phase_q;
		use_saved = 1'b0;
		pre       = 1'b0;
		len_dec   = len_q;
		if (phase_q != tsp_pkg::PH_STOPPED) begin
			if (item.shutdown) begin
				n_phase = tsp_pkg::PH_STOPPED;
				n_tick  = '0;
				n_len   = 8'd0;
			end else begin
				if (item.ped_request && !ped_q && !emg_q) begin
					n_ped     = 1'b1;
					n_ped_dir = item.ped_direction;
				end
				if (item.emergency_request) begin
					n_emg     = 1'b1;
					n_emg_dir = item.emergency_approach;
				end
				if (rm_q == tsp_pkg::RM_NORMAL && n_emg
						&& phase_q != tsp_pkg::PH_EMG_GREEN
						&& phase_q != tsp_pkg::PH_EMG_YELLOW) begin
					// emergency preempts any cycle phase or a walk
					if (phase_q == tsp_pkg::PH_WALK)
						n_saved = (tick_q != '0 && len_q != 8'd0) ? len_q - 8'd1 : len_q;
					else
						n_saved = 8'd0;
					n_serv   = n_emg_dir;
					n_emg    = 1'b0;
					enter_en = 1'b1;
					if (slot == tsp_pkg::SLOT_GREEN || slot == tsp_pkg::SLOT_YELLOW) begin
						n_rm     = tsp_pkg::RM_TO_EMG;
						enter_ph = tsp_pkg::phase_t'(phase_q + 4'd1);
					end else begin
						enter_ph = tsp_pkg::PH_EMG_GREEN;
					end
					pre = 1'b1;
				end else if (rm_q == tsp_pkg::RM_NORMAL && n_ped
						&& slot == tsp_pkg::SLOT_GREEN) begin
					n_ped    = 1'b0;
					n_rm     = tsp_pkg::RM_TO_WALK;
					enter_en = 1'b1;
					enter_ph = tsp_pkg::phase_t'(phase_q + 4'd1);
					pre      = 1'b1;
				end
				if (!pre) begin
					if (tick_inc >= (TICK_W+1)'(TICKS_PER_SECOND)) begin
						n_tick = '0;
						if (len_q != 8'd0) len_dec = len_q - 8'd1;
					end else begin
						n_tick = tick_inc[TICK_W-1:0];
					end
					n_len = len_dec;
					if (len_dec == 8'd0) begin
						enter_en = 1'b1;
						if (rm_q == tsp_pkg::RM_TO_EMG) begin
							if (slot == tsp_pkg::SLOT_YELLOW) begin
								enter_ph = tsp_pkg::phase_t'(phase_q + 4'd1);
							end else begin
								n_rm     = tsp_pkg::RM_NORMAL;
								enter_ph = tsp_pkg::PH_EMG_GREEN;
							end
						end else if (rm_q == tsp_pkg::RM_TO_WALK) begin
							if (slot == tsp_pkg::SLOT_YELLOW) begin
								enter_ph = tsp_pkg::phase_t'(phase_q + 4'd1);
							end else begin
								n_rm     = tsp_pkg::RM_NORMAL;
								enter_ph = tsp_pkg::PH_WALK;
							end
						end else if (rm_q == tsp_pkg::RM_EXIT
								|| phase_q == tsp_pkg::PH_EMG_YELLOW) begin
							if (phase_q == tsp_pkg::PH_EMG_YELLOW) begin
								n_rm     = tsp_pkg::RM_EXIT;
								enter_ph = tsp_pkg::PH_NS_RED;
							end else begin
								n_rm = tsp_pkg::RM_NORMAL;
								if (saved_q != 8'd0) begin
									// resume an interrupted walk
									enter_ph  = tsp_pkg::PH_WALK;
									use_saved = 1'b1;
									n_saved   = 8'd0;
								end else begin
									enter_ph = tsp_pkg::PH_NS_LEFT_GREEN;
								end
							end
						end else if (slot != tsp_pkg::SLOT_SPECIAL) begin
							enter_ph = (phase_q == tsp_pkg::PH_EW_RED) ?
								tsp_pkg::PH_NS_LEFT_GREEN : tsp_pkg::phase_t'(phase_q + 4'd1);
						end else if (phase_q == tsp_pkg::PH_WALK) begin
							n_rm     = tsp_pkg::RM_EXIT;
							n_saved  = 8'd0;
							enter_ph = tsp_pkg::PH_NS_RED;
						end else begin
							// emergency green hold ends
							n_rm     = tsp_pkg::RM_EXIT;
							enter_ph = tsp_pkg::PH_EMG_YELLOW;
						end
					end
				end
				if (enter_en) begin
					n_phase = enter_ph;
					n_tick  = '0;
					n_len   = use_saved ? saved_q : enter_len;
				end
			end
		end
	end

	// length of a phase being entered
	always_comb begin
		case (enter_ph)
			tsp_pkg::PH_STOPPED:    enter_len = 8'd0;
			tsp_pkg::PH_WALK:       enter_len = cfg.walk_secs;
			tsp_pkg::PH_EMG_GREEN:  enter_len = tsp_pkg::EMERGENCY_HOLD_SECS;
			tsp_pkg::PH_EMG_YELLOW: enter_len = cfg.yellow_secs;
			tsp_pkg::PH_NS_GREEN:   enter_len = ns_len;
			tsp_pkg::PH_EW_GREEN:   enter_len = ew_len;
			tsp_pkg::PH_NS_LEFT_GREEN, tsp_pkg::PH_EW_LEFT_GREEN:
				enter_len = cfg.left_green_secs;
			tsp_pkg::PH_NS_LEFT_YELLOW, tsp_pkg::PH_NS_YELLOW,
			tsp_pkg::PH_EW_LEFT_YELLOW, tsp_pkg::PH_EW_YELLOW:
				enter_len = cfg.yellow_secs;
			default: enter_len = cfg.all_red_secs;
		endcase
	end

	// outputs
	always_comb begin
		res.phase       = n_phase;
		res.secs_rem    = n_len;
		res.serving_dir = n_serv;
		res.ped_latched = n_ped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tsp_pkg::PH_NS_LEFT_GREEN;
			rm_q      <= tsp_pkg::RM_NORMAL;
			tick_q    <= '0;
			len_q     <= tsp_pkg::RST_LEFT_GREEN;
			ped_q     <= 1'b0;
			ped_dir_q <= 2'd0;
			emg_q     <= 1'b0;
			emg_dir_q <= 2'd0;
			serv_q    <= 2'd0;
			saved_q   <= 8'd0;
		end else if (step_en) begin
			phase_q   <= n_phase;
			rm_q      <= n_rm;
			tick_q    <= n_tick;
			len_q     <= n_len;
			ped_q     <= n_ped;
			ped_dir_q <= n_ped_dir;
			emg_q     <= n_emg;
			emg_dir_q <= n_emg_dir;
			serv_q    <= n_serv;
			saved_q   <= n_saved;
		end
	end

endmodule

>>> rtl/core/tsp_out.sv
// tsp_out: result register with light decode and valid/stall handshake
// depends on tsp_pkg
`timescale 1ns / 1ps

module tsp_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tsp_pkg::step_res_t  res,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [3:0]          phase,
	output logic [7:0]          straight_lights,
	output logic [7:0]          left_lights,
	output logic                walk_active,
	output logic                emergency_active,
	output logic [1:0]          served_emergency_dir,
	output logic                ped_pending,
	output logic [7:0]          seconds_remaining
);

	logic [7:0] s_dec, l_dec, pair_green, pair_yellow;
	logic       valid_q;

	assign pair_green  = {4'd0, tsp_pkg::LIGHT_GREEN, tsp_pkg::LIGHT_GREEN};
	assign pair_yellow = {4'd0, tsp_pkg::LIGHT_YELLOW, tsp_pkg::LIGHT_YELLOW};

	always_comb begin
		s_dec = 8'd0;
		l_dec = 8'd0;
		case (res.phase)
			tsp_pkg::PH_NS_LEFT_GREEN:  l_dec = pair_green;
			tsp_pkg::PH_NS_LEFT_YELLOW: l_dec = pair_yellow;
			tsp_pkg::PH_NS_GREEN:       s_dec = pair_green;
			tsp_pkg::PH_NS_YELLOW:      s_dec = pair_yellow;
			tsp_pkg::PH_EW_LEFT_GREEN:  l_dec = pair_green << 4;
			tsp_pkg::PH_EW_LEFT_YELLOW: l_dec = pair_yellow << 4;
			tsp_pkg::PH_EW_GREEN:       s_dec = pair_green << 4;
			tsp_pkg::PH_EW_YELLOW:      s_dec = pair_yellow << 4;
			tsp_pkg::PH_EMG_GREEN:
				s_dec = {6'd0, tsp_pkg::LIGHT_GREEN} << {res.serving_dir, 1'b0};
			tsp_pkg::PH_EMG_YELLOW:
				s_dec = {6'd0, tsp_pkg::LIGHT_YELLOW} << {res.serving_dir, 1'b0};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= load | (valid_q & out_stall);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			phase                <= res.phase;
			straight_lights      <= s_dec;
			left_lights          <= l_dec;
			walk_active          <= (res.phase == tsp_pkg::PH_WALK);
			emergency_active     <= (res.phase == tsp_pkg::PH_EMG_GREEN);
			served_emergency_dir <= res.serving_dir;
			ped_pending          <= res.ped_latched;
			seconds_remaining    <= (res.phase == tsp_pkg::PH_STOPPED) ? 8'd0 : res.secs_rem;
		end
	end

	assign out_valid = valid_q;

endmodule

>>> rtl/core/traffic_signal_phase_controller.sv
// traffic_signal_phase_controller: top level with input register, phase
// controller and result register; depends on tsp_pkg, tsp_cfg, tsp_ctrl, tsp_out
`timescale 1ns / 1ps

// four-way signal controller stepped by one tick item (TICKS_PER_SECOND ticks
// make a second). each accepted item produces exactly one result item holding
// the phase, both light sets and the seconds left. throughput is one item per
// clock while the result channel is not stalled; the accepting edge loads the
// input register, and the combinational state update is loaded into the result
// register once that register is empty or being drained.
// the phase state machine updates once per cycle unless the result stalls,
// so items may arrive back to back; the input register absorbs one item
// while a result waits under stall. configuration registers sit at byte
// address 4*index and should only be written while no item is in flight.
// there is no start-up clearing pass: the block takes items right after reset.

module traffic_signal_phase_controller #(
	parameter int TICKS_PER_SECOND = tsp_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tsp_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// input item channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           ped_request,
	input  logic [1:0]                     ped_direction,
	input  logic                           emergency_request,
	input  logic [1:0]                     emergency_approach,
	input  logic [7:0]                     ns_vehicles,
	input  logic [7:0]                     ew_vehicles,
	input  logic                           shutdown,
	// result item channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     phase,
	output logic [7:0]                     straight_lights,
	output logic [7:0]                     left_lights,
	output logic                           walk_active,
	output logic                           emergency_active,
	output logic [1:0]                     served_emergency_dir,
	output logic                           ped_pending,
	output logic [7:0]                     seconds_remaining
);

	tsp_pkg::cfg_t      cfg;
	tsp_pkg::in_item_t  item_s1;
	tsp_pkg::step_res_t res;
	logic               valid_s1;
	logic               step_go;
	logic               in_take;

	// the item in the input register steps the controller whenever the
	// result register is empty or being drained this cycle
	assign step_go  = valid_s1 & (~out_valid | ~out_stall);
	assign in_stall = valid_s1 & ~step_go;
	assign in_take  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_take | (valid_s1 & ~step_go);
	end

	// input item register, payload only
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.ped_request        <= ped_request;
			item_s1.ped_direction      <= ped_direction;
			item_s1.emergency_request  <= emergency_request;
			item_s1.emergency_approach <= emergency_approach;
			item_s1.ns_vehicles        <= ns_vehicles;
			item_s1.ew_vehicles        <= ew_vehicles;
			item_s1.shutdown           <= shutdown;
		end
	end

	tsp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// phase state machine: shutdown, request latching, preemption, countdown
	tsp_ctrl #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_go),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	tsp_out u_out (
		.clk                  (clk),
		.arst_n               (arst_n),
		.load                 (step_go),
		.res                  (res),
		.out_stall            (out_stall),
		.out_valid            (out_valid),
		.phase                (phase),
		.straight_lights      (straight_lights),
		.left_lights          (left_lights),
		.walk_active          (walk_active),
		.emergency_active     (emergency_active),
		.served_emergency_dir (served_emergency_dir),
		.ped_pending          (ped_pending),
		.seconds_remaining    (seconds_remaining)
	);

endmodule
